// File: sv/cvhe_pkg.sv
package cvhe_pkg;

    typedef enum logic [1:0] {
        SZ_1,
        SZ_2,
        SZ_4,
        SZ_8
    } size_t;

    typedef enum logic [1:0] {
        SEL_PFX_F,
        SEL_PFX_X,
        SEL_HI,
        SEL_LO
    } char_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PFX0,
        ST_PFX1,
        ST_HI,
        ST_LO
    } state_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        char_sel_t sel;
        logic      last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic  out_free;
        size_t size_in;
    } dp_status_t;

    localparam logic [63:0] SMALL_LIMIT = 64'h0000_0000_0000_00fd;
    localparam logic [6:0]  CHAR_D      = 7'h64;
    localparam logic [6:0]  CHAR_E      = 7'h65;
    localparam logic [6:0]  CHAR_F      = 7'h66;
    localparam logic [6:0]  DIGIT_BASE  = 7'h30;
    localparam logic [6:0]  ALPHA_BASE  = 7'h57;

    function automatic logic [6:0] nibble_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return DIGIT_BASE + {3'b000, nib};
        end
        return ALPHA_BASE + {3'b000, nib};
    endfunction

    function automatic size_t size_of(input logic [63:0] v);
        if (v < SMALL_LIMIT)
        begin
            return SZ_1;
        end
        else if (v[63:16] == 48'd0)
        begin
            return SZ_2;
        end
        else if (v[63:32] == 32'd0)
        begin
            return SZ_4;
        end
        return SZ_8;
    endfunction

    function automatic logic [4:0] size_chars(input size_t s);
        case (s)
            SZ_1:    return 5'd2;
            SZ_2:    return 5'd4;
            SZ_4:    return 5'd8;
            default: return 5'd16;
        endcase
    endfunction

    function automatic logic [2:0] size_last_byte(input size_t s);
        case (s)
            SZ_1:    return 3'd0;
            SZ_2:    return 3'd1;
            SZ_4:    return 3'd3;
            default: return 3'd7;
        endcase
    endfunction

    function automatic logic [6:0] prefix_char(input size_t s);
        case (s)
            SZ_2:    return CHAR_D;
            SZ_4:    return CHAR_E;
            default: return CHAR_F;
        endcase
    endfunction

endpackage

// File: sv/cvhe_in_if.sv
interface cvhe_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

// File: sv/cvhe_out_if.sv
interface cvhe_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] hex_char;
    logic       last_char;
    logic [4:0] payload_chars;

    modport source (output valid, output hex_char, output last_char, output payload_chars,
                    input ready);
    modport sink (input valid, input hex_char, input last_char, input payload_chars,
                  output ready);
endinterface

// File: sv/compactsize_varint_hex_encoder.sv
// CompactSize varint encoder producing lowercase ASCII hex, one character per transaction on
// chars. A value on values becomes 2 characters (below 0xfd), or a two-character prefix
// "fd", "fe" or "ff" followed by 4, 8 or 16 characters of the value, least significant byte
// first and high nibble first within a byte; the last character carries last_char and every
// character carries payload_chars. The single output register issues one character per cycle
// while chars is ready and holds it while chars is not; the next value is taken in the cycle
// of the previous value's last character, so items follow without a gap. No state needs
// clearing after reset.
module compactsize_varint_hex_encoder (
    input  logic      clk,
    input  logic      rst_n,
    cvhe_in_if.sink   values,
    cvhe_out_if.source chars
);
    import cvhe_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    cvhe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (values.valid),
        .in_ready (values.ready),
        .status   (status),
        .cmd      (cmd)
    );

    cvhe_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .value         (values.value),
        .out_ready     (chars.ready),
        .out_valid     (chars.valid),
        .hex_char      (chars.hex_char),
        .last_char     (chars.last_char),
        .payload_chars (chars.payload_chars)
    );

endmodule

// File: sv/cvhe_dp.sv
module cvhe_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  cvhe_pkg::ctrl_cmd_t cmd,
    output cvhe_pkg::dp_status_t status,
    input  logic [63:0]         value,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [6:0]          hex_char,
    output logic                last_char,
    output logic [4:0]          payload_chars
);
    import cvhe_pkg::*;

    logic [63:0] value_reg;
    size_t       size_reg;
    logic        out_valid_reg;
    logic [6:0]  hex_char_reg;
    logic        last_char_reg;
    logic [4:0]  payload_chars_reg;
    logic [6:0]  char_next;

    always_comb
    begin
        case (cmd.sel)
            SEL_PFX_F: char_next = CHAR_F;
            SEL_PFX_X: char_next = prefix_char(size_reg);
            SEL_HI:    char_next = nibble_char(value_reg[7:4]);
            SEL_LO:    char_next = nibble_char(value_reg[3:0]);
            default:   char_next = CHAR_F;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= value;
            size_reg  <= size_of(value);
        end
        else if (cmd.emit && cmd.sel == SEL_LO)
        begin
            value_reg <= {8'd0, value_reg[63:8]};
        end
        if (cmd.emit)
        begin
            hex_char_reg      <= char_next;
            last_char_reg     <= cmd.last;
            payload_chars_reg <= size_chars(size_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign status.size_in  = size_of(value);
    assign out_valid       = out_valid_reg;
    assign hex_char        = hex_char_reg;
    assign last_char       = last_char_reg;
    assign payload_chars   = payload_chars_reg;

endmodule

// File: sv/cvhe_ctrl.sv
module cvhe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cvhe_pkg::dp_status_t status,
    output cvhe_pkg::ctrl_cmd_t  cmd
);
    import cvhe_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] byte_cnt_reg;
    logic [2:0] byte_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            byte_cnt_reg <= 3'd0;
        end
        else
        begin
            state_reg    <= state_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        byte_cnt_next = byte_cnt_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.emit      = 1'b0;
        cmd.sel       = SEL_HI;
        cmd.last      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_PFX0:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_PFX_F;
                    state_next = ST_PFX1;
                end
            end
            ST_PFX1:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_PFX_X;
                    state_next = ST_HI;
                end
            end
            ST_HI:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_HI;
                    state_next = ST_LO;
                end
            end
            ST_LO:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_LO;
                    if (byte_cnt_reg == 3'd0)
                    begin
                        cmd.last   = 1'b1;
                        in_ready   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        byte_cnt_next = byte_cnt_reg - 3'd1;
                        state_next    = ST_HI;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // new transaction, possibly taken alongside the final character
        if (in_ready && in_valid)
        begin
            cmd.load      = 1'b1;
            byte_cnt_next = size_last_byte(status.size_in);
            state_next    = (status.size_in == SZ_1) ? ST_HI : ST_PFX0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("character emitted while output register busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == ST_IDLE || (state_reg == ST_LO && cmd.last)))
        else $error("value loaded while encoding in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && status.size_in == SZ_1 |=> state_reg == ST_HI && byte_cnt_reg == 3'd0)
        else $error("single byte value did not skip prefix");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && status.size_in != SZ_1 |=> state_reg == ST_PFX0)
        else $error("prefixed value did not start with prefix");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cvhe_pkg::*;

    typedef struct packed {
        logic [6:0] hex_char;
        logic       last_char;
        logic [4:0] payload_chars;
    } enc_char_t;

    localparam int DIR_N          = 18;
    localparam int RAND_N         = 152;
    localparam int HOLDOFF_AT     = 70;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int PAUSE_AT       = 100;
    localparam int BURST_LEN      = 30;
    localparam int DRAIN_CYCLES   = 40;

    logic clk;
    logic rst_n;

    cvhe_in_if  values_if ();
    cvhe_out_if chars_if ();

    compactsize_varint_hex_encoder i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .values (values_if),
        .chars  (chars_if)
    );

    enc_char_t pending_chars [$];
    int        mismatches      = 0;
    int        chars_checked   = 0;
    int        values_accepted = 0;
    bit        holdoff_done    = 1'b0;

    // empty text means the predictor supplies the expected characters
    logic [63:0] dir_value [DIR_N] = '{
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0001,
        64'h0000_0000_0000_00fc,
        64'h0000_0000_0000_00fd,
        64'h0000_0000_0000_00fe,
        64'h0000_0000_0000_ffff,
        64'h0000_0000_0001_0000,
        64'h0000_0000_ffff_ffff,
        64'h0000_0001_0000_0000,
        64'hffff_ffff_ffff_ffff,
        64'h8000_0000_0000_0000,
        64'h0000_0000_0000_00ab,
        64'h0000_0000_0000_1234,
        64'h0000_0000_dead_beef,
        64'h0123_4567_89ab_cdef,
        64'hfedc_ba98_7654_3210,
        64'h5555_5555_5555_5555,
        64'haaaa_aaaa_aaaa_aaaa
    };
    string dir_text [DIR_N] = '{
        "00",
        "01",
        "fc",
        "fdfd00",
        "fdfe00",
        "fdffff",
        "fe00000100",
        "feffffffff",
        "ff0000000001000000",
        "ffffffffffffffffff",
        "ff0000000000000080",
        "", "", "", "", "", "", ""
    };

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic [6:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return 7'(8'h30 + n);
        end
        return 7'(8'h61 + n - 8'd10);
    endfunction

    function automatic void push_char(input logic [6:0] ch, input logic last,
                                      input logic [4:0] plen);
        enc_char_t c;
        c.hex_char      = ch;
        c.last_char     = last;
        c.payload_chars = plen;
        pending_chars.push_back(c);
    endfunction

    function automatic void encode_compactsize(input logic [63:0] v);
        size_t      sz;
        int         nbytes;
        logic [4:0] plen;
        logic [7:0] b;
        if (v < 64'h0000_0000_0000_00fd)
        begin
            sz = SZ_1;
        end
        else if (v <= 64'h0000_0000_0000_ffff)
        begin
            sz = SZ_2;
        end
        else if (v <= 64'h0000_0000_ffff_ffff)
        begin
            sz = SZ_4;
        end
        else
        begin
            sz = SZ_8;
        end
        nbytes = 1 << int'(sz);
        plen   = 5'(2 * nbytes);
        if (sz != SZ_1)
        begin
            push_char(CHAR_F, 1'b0, plen);
            push_char((sz == SZ_2) ? CHAR_D : (sz == SZ_4) ? CHAR_E : CHAR_F, 1'b0, plen);
        end
        for (int k = 0; k < nbytes; k++)
        begin
            b = v[8*k +: 8];
            push_char(hex_digit(b[7:4]), 1'b0, plen);
            push_char(hex_digit(b[3:0]), k == nbytes - 1, plen);
        end
    endfunction

    function automatic void queue_typed(input string text);
        logic [4:0] plen;
        plen = (text.len() == 2) ? 5'd2 : 5'(text.len() - 2);
        for (int i = 0; i < text.len(); i++)
        begin
            push_char(7'(text[i]), i == text.len() - 1, plen);
        end
    endfunction

    task automatic send_value(input logic [63:0] v, input string text);
        values_if.valid <= 1'b1;
        values_if.value <= v;
        do
            @(posedge clk);
        while (!values_if.ready);
        if (text.len() != 0)
        begin
            queue_typed(text);
        end
        else
        begin
            encode_compactsize(v);
        end
        values_accepted++;
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            values_if.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        values_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_chars.size() != 0);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5)
        begin
            return 0;
        end
        else if (r <= 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] edges [6];
        logic [63:0] v;
        edges = '{64'h0, 64'hfd, 64'h1_0000, 64'h1_0000_0000, 64'hffff_ffff_ffff_fffe, 64'h100};
        case ($urandom_range(0, 5))
            0: v = 64'($urandom_range(0, 252));
            1: v = 64'($urandom_range(253, 65535));
            2: v = {32'h0, $urandom};
            3, 4: v = {$urandom, $urandom};
            default: v = edges[$urandom_range(0, 5)] + 64'($urandom_range(0, 4)) - 64'd2;
        endcase
        return v;
    endfunction

    initial
    begin
        #20_000_000;
        $display("timeout with %0d characters still expected", pending_chars.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver side, including one long hold-off to back the block up
    initial
    begin
        int run;
        chars_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!holdoff_done && values_accepted >= HOLDOFF_AT)
            begin
                chars_if.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                holdoff_done = 1'b1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                chars_if.ready <= 1'b1;
                repeat (60) @(posedge clk);
            end
            else
            begin
                chars_if.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                chars_if.ready <= 1'b0;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
                repeat (run) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        enc_char_t want;
        if (rst_n && chars_if.valid && chars_if.ready)
        begin
            chars_checked++;
            if (pending_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected char 0x%02h", chars_if.hex_char));
            end
            else
            begin
                want = pending_chars.pop_front();
                if (chars_if.hex_char !== want.hex_char)
                begin
                    report_mismatch($sformatf("hex_char 0x%02h, want 0x%02h",
                                              chars_if.hex_char, want.hex_char));
                end
                if (chars_if.last_char !== want.last_char)
                begin
                    report_mismatch($sformatf("last_char %0b, want %0b",
                                              chars_if.last_char, want.last_char));
                end
                if (chars_if.payload_chars !== want.payload_chars)
                begin
                    report_mismatch($sformatf("payload_chars %0d, want %0d",
                                              chars_if.payload_chars, want.payload_chars));
                end
            end
        end
    end

    initial
    begin
        values_if.valid <= 1'b0;
        values_if.value <= '0;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            send_value(dir_value[i], dir_text[i]);
            idle_gap(pick_gap());
        end
        wait_drained();

        for (int i = 0; i < RAND_N; i++)
        begin
            send_value(random_value(), "");
            if (i == PAUSE_AT)
            begin
                wait_drained();
            end
            else if (i >= BURST_LEN)
            begin
                idle_gap(pick_gap());
            end
        end
        values_if.valid <= 1'b0;

        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("encoded %0d values into %0d hex characters, all four prefix sizes and",
                 values_accepted, chars_checked);
        $display("a %0d-cycle output hold-off included; %0d mismatches",
                 HOLDOFF_CYCLES, mismatches);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
